// ===== hdl/keyed_queue_remove_compact_unit_defines.svh =====
// Assertion macros for the keyed queue remove/compact unit.
`ifndef KEYED_QUEUE_REMOVE_COMPACT_UNIT_DEFINES_SVH
`define KEYED_QUEUE_REMOVE_COMPACT_UNIT_DEFINES_SVH

// same-cycle implication
`define KQRC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kqrc assertion failed");

// next-cycle implication
`define KQRC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kqrc assertion failed");

`endif

// ===== hdl/kqrc_pkg.sv =====
// Package: types, constants and key canonicalization for the keyed queue.
`default_nettype none
package kqrc_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_W       = 72;
	localparam int AGE_W       = 8;
	localparam int STATUS_W    = 3;
	localparam int ECNT_W      = 4;

	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [AGE_W-1:0]    age_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_APPENDED  = 3'd0;
	localparam status_t ST_FULL      = 3'd1;
	localparam status_t ST_REMOVED   = 3'd2;
	localparam status_t ST_NOT_FOUND = 3'd3;
	localparam status_t ST_EMPTY     = 3'd4;

	typedef struct packed {
		logic wr_en;
		logic load;
		logic step;
		logic in_use;
	} cell_ctl_t;

	// zero every byte after the first zero byte
	function automatic key_t canon_key(input logic [63:0] lo, input logic [7:0] hi);
		logic ended;
		key_t k;
		ended = 1'b0;
		k = '0;
		for (int b = 0; b < 8; b++) begin
			if (lo[8*b +: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				k[8*b +: 8] = lo[8*b +: 8];
		end
		if (!ended)
			k[71:64] = hi;
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/kqrc_cell.sv =====
// One queue cell: entry storage, key match and the compaction swap step.
`default_nettype none
module kqrc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  kqrc_pkg::cell_ctl_t ctl,
	input  kqrc_pkg::key_t    key,
	input  kqrc_pkg::age_t    age_wr,
	input  kqrc_pkg::key_t    nxt_name,
	input  kqrc_pkg::age_t    nxt_age,
	input  logic              nxt_dead,
	input  logic              prv_dead,
	output kqrc_pkg::key_t    name,
	output kqrc_pkg::age_t    age,
	output logic              dead,
	output logic              hit,
	output logic              pair
);
	import kqrc_pkg::*;

	key_t name_q;
	age_t age_q;
	logic dead_q;

	assign hit  = ctl.in_use && (name_q == key);
	assign pair = dead_q && !nxt_dead;
	assign name = name_q;
	assign age  = age_q;
	assign dead = dead_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			name_q <= key;
			age_q  <= age_wr;
		end else if (ctl.step && pair) begin
			name_q <= nxt_name;
			age_q  <= nxt_age;
		end
	end

	// dead slot pulls a live neighbor; the live one giving it up turns dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q <= 1'b0;
		end else if (ctl.load) begin
			dead_q <= !ctl.in_use || hit;
		end else if (ctl.step) begin
			if (pair)
				dead_q <= 1'b0;
			else if (!dead_q && prv_dead)
				dead_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/keyed_queue_remove_compact_unit.sv =====
// Top level: keyed queue with append and remove-all-by-key with compaction.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, op, name_low/high, age | request in
//  out     | out_valid, out_stall, status, entry_count  | result out
//
// Append, full, empty and no-match requests pass EXEC and FIN, which raises out_valid.
// A remove with matches also passes COMPACT; the swap passes of the cell chain that
// move freed slots to the tail never outlast the count scan.
// Reset clears the count, the state and the output valid; entries are not cleared.
// A result waiting under out_stall does not block the next request from entering;
// that request finishes once the output register is free.
`default_nettype none
`include "keyed_queue_remove_compact_unit_defines.svh"
module keyed_queue_remove_compact_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [63:0] name_low,
	input  logic [7:0]  name_high,
	input  logic [7:0]  age,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  entry_count
);
	import kqrc_pkg::*;

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_EXEC    = 2'd1;
	localparam logic [1:0] S_COMPACT = 2'd2;
	localparam logic [1:0] S_FIN     = 2'd3;

	logic [1:0]             state_q;
	logic                   op_q;
	key_t                   key_q;
	age_t                   age_q;
	cnt_t                   count_q;
	cnt_t                   scan_q;
	cnt_t                   removed_q;
	logic [QUEUE_DEPTH-1:0] hit_sr_q;
	status_t                res_q;
	logic                   out_valid_q;
	status_t                status_q;
	logic [ECNT_W-1:0]      ecnt_q;

	key_t                   cname [QUEUE_DEPTH];
	age_t                   cage  [QUEUE_DEPTH];
	key_t                   nname [QUEUE_DEPTH];
	age_t                   nage  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cdead, ndead, pdead, chit, cpair;
	cell_ctl_t              cctl  [QUEUE_DEPTH];

	logic                    in_accept;
	logic                    out_free;
	logic                    any_hit;
	logic                    any_pair;
	logic                    compact_done;
	logic [CNT_W+ECNT_W-1:0] cnt_ext;

	assign in_stall     = (state_q != S_IDLE);
	assign in_accept    = in_valid && (state_q == S_IDLE);
	assign out_free     = !out_valid_q || !out_stall;
	assign any_hit      = |chit;
	assign any_pair     = |cpair;
	assign compact_done = (state_q == S_COMPACT) && (scan_q == '0) && !any_pair;
	assign cnt_ext      = {{ECNT_W{1'b0}}, count_q};

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			if (i == QUEUE_DEPTH - 1) begin : g_tail
				assign nname[i] = '0;
				assign nage[i]  = '0;
				assign ndead[i] = 1'b1;
			end else begin : g_mid
				assign nname[i] = cname[i+1];
				assign nage[i]  = cage[i+1];
				assign ndead[i] = cdead[i+1];
			end
			if (i == 0) begin : g_head
				assign pdead[i] = 1'b0;
			end else begin : g_body
				assign pdead[i] = cdead[i-1];
			end

			assign cctl[i].wr_en  = (state_q == S_EXEC) && !op_q && (count_q == cnt_t'(i));
			assign cctl[i].load   = (state_q == S_EXEC) && op_q;
			assign cctl[i].step   = (state_q == S_COMPACT);
			assign cctl[i].in_use = (cnt_t'(i) < count_q);

			kqrc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (cctl[i]),
				.key      (key_q),
				.age_wr   (age_q),
				.nxt_name (nname[i]),
				.nxt_age  (nage[i]),
				.nxt_dead (ndead[i]),
				.prv_dead (pdead[i]),
				.name     (cname[i]),
				.age      (cage[i]),
				.dead     (cdead[i]),
				.hit      (chit[i]),
				.pair     (cpair[i])
			);
		end
	endgenerate

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (!op_q) begin
						if (count_q != cnt_t'(QUEUE_DEPTH))
							count_q <= count_q + cnt_t'(1);
						state_q <= S_FIN;
					end else if (count_q == '0 || !any_hit) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_COMPACT;
					end
				end
				S_COMPACT: begin
					if (compact_done) begin
						count_q <= count_q - removed_q;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q  <= op;
			key_q <= canon_key(name_low, name_high);
			age_q <= age;
		end

		if (state_q == S_EXEC) begin
			if (!op_q) begin
				res_q <= (count_q == cnt_t'(QUEUE_DEPTH)) ? ST_FULL : ST_APPENDED;
			end else if (count_q == '0) begin
				res_q <= ST_EMPTY;
			end else if (!any_hit) begin
				res_q <= ST_NOT_FOUND;
			end else begin
				res_q     <= ST_REMOVED;
				hit_sr_q  <= chit;
				scan_q    <= count_q;
				removed_q <= '0;
			end
		end

		if (state_q == S_COMPACT && scan_q != '0) begin
			scan_q    <= scan_q - cnt_t'(1);
			hit_sr_q  <= hit_sr_q >> 1;
			removed_q <= removed_q + cnt_t'(hit_sr_q[0]);
		end

		if (state_q == S_FIN && out_free) begin
			status_q <= res_q;
			ecnt_q   <= cnt_ext[ECNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = ecnt_q;

	`KQRC_ASSERT_IMP(a_count_bound, 1'b1, count_q <= cnt_t'(QUEUE_DEPTH))
	`KQRC_ASSERT_NXT(a_remove_shrinks, compact_done, count_q < $past(count_q))
	`KQRC_ASSERT_NXT(a_fin_loads_out, (state_q == S_FIN) && out_free, out_valid_q && !in_stall)
	`KQRC_ASSERT_NXT(a_compact_has_hit, (state_q == S_EXEC) && op_q && any_hit, state_q == S_COMPACT)
	`KQRC_ASSERT_NXT(a_out_hold, out_valid_q && out_stall, out_valid_q && $stable(status_q))

endmodule
`default_nettype wire

// ===== tb/keyed_queue_remove_compact_unit_tb.sv =====
// Testbench for the keyed queue unit: appends, keyed removals, status and count checks.
`timescale 1ns / 1ps
module keyed_queue_remove_compact_unit_tb;
	import kqrc_pkg::*;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_REMOVE = 1'b1;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int NAME_POOL = 6;

	typedef struct packed {
		logic        op;
		logic [63:0] name_low;
		logic [7:0]  name_high;
		logic [7:0]  age;
	} request_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] entry_count;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic [63:0] name_low = '0;
	logic [7:0]  name_high = '0;
	logic [7:0]  age = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [3:0]  entry_count;

	request_t queued_requests[$];
	outcome_t pending_outcomes[$];
	int requests_issued = 0;
	int requests_accepted = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;

	key_t        held_names[QUEUE_DEPTH];
	age_t        held_ages[QUEUE_DEPTH];
	int unsigned held_count = 0;

	keyed_queue_remove_compact_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.name_low(name_low),
		.name_high(name_high),
		.age(age),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_count(entry_count)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	// a name ends at its first zero byte; everything after it counts as zero
	function automatic key_t trimmed_name(input logic [63:0] lo, input logic [7:0] hi);
		key_t raw;
		int len;
		raw = {hi, lo};
		len = 9;
		for (int b = 8; b >= 0; b--)
			if (raw[8*b +: 8] == 8'd0)
				len = b;
		for (int b = 0; b < 9; b++)
			if (b >= len)
				raw[8*b +: 8] = 8'd0;
		return raw;
	endfunction

	function automatic outcome_t queue_outcome(input request_t r);
		key_t key;
		outcome_t o;
		int unsigned kept;
		key = trimmed_name(r.name_low, r.name_high);
		if (r.op == OP_APPEND) begin
			if (held_count >= QUEUE_DEPTH) begin
				o.status = ST_FULL;
			end else begin
				held_names[held_count] = key;
				held_ages[held_count] = r.age;
				held_count++;
				o.status = ST_APPENDED;
			end
		end else if (held_count == 0) begin
			o.status = ST_EMPTY;
		end else begin
			kept = 0;
			for (int unsigned i = 0; i < held_count; i++) begin
				if (held_names[i] != key) begin
					held_names[kept] = held_names[i];
					held_ages[kept] = held_ages[i];
					kept++;
				end
			end
			if (kept == held_count) begin
				o.status = ST_NOT_FOUND;
			end else begin
				held_count = kept;
				o.status = ST_REMOVED;
			end
		end
		o.entry_count = held_count[3:0];
		return o;
	endfunction

	task automatic enqueue(input logic o, input logic [63:0] lo, input logic [7:0] hi,
			input logic [7:0] a);
		request_t r;
		r.op = o;
		r.name_low = lo;
		r.name_high = hi;
		r.age = a;
		queued_requests.push_back(r);
		requests_issued++;
	endtask

	function automatic key_t random_name();
		key_t k;
		int len;
		len = $urandom_range(9);
		for (int b = 0; b < 9; b++)
			k[8*b +: 8] = (b < len) ? 8'($urandom_range(255, 1)) : 8'd0;
		return k;
	endfunction

	// junk after the terminating zero byte; must still match the clean name
	function automatic key_t scramble_tail(input key_t k);
		logic ended;
		ended = 1'b0;
		for (int b = 0; b < 9; b++) begin
			if (ended)
				k[8*b +: 8] = 8'($urandom_range(255));
			else if (k[8*b +: 8] == 8'd0)
				ended = 1'b1;
		end
		return k;
	endfunction

	task automatic queue_random_requests(input int n);
		key_t pool[NAME_POOL];
		key_t k;
		int append_pct;
		logic o;
		for (int p = 0; p < NAME_POOL; p++)
			pool[p] = random_name();
		append_pct = 60;
		for (int i = 0; i < n; i++) begin
			if (i % 12 == 0) begin
				case ($urandom_range(2))
					0: append_pct = 30;
					1: append_pct = 60;
					default: append_pct = 85;
				endcase
			end
			if ($urandom_range(99) < 8) begin
				k[31:0] = $urandom;
				k[63:32] = $urandom;
				k[71:64] = 8'($urandom_range(255));
			end else begin
				k = pool[$urandom_range(NAME_POOL - 1)];
				if ($urandom_range(99) < 40)
					k = scramble_tail(k);
			end
			o = ($urandom_range(99) < append_pct) ? OP_APPEND : OP_REMOVE;
			enqueue(o, k[63:0], k[71:64], 8'($urandom_range(255)));
		end
	endtask

	task automatic wait_drained();
		while (requests_accepted < requests_issued || pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_requests
		request_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= 1'b0;
			name_low <= '0;
			name_high <= '0;
			age <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				r.op = op;
				r.name_low = name_low;
				r.name_high = name_high;
				r.age = age;
				pending_outcomes.push_back(queue_outcome(r));
				requests_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (queued_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					r = queued_requests.pop_front();
					in_valid <= 1'b1;
					op <= r.op;
					name_low <= r.name_low;
					name_high <= r.name_high;
					age <= r.age;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : check_results
		outcome_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch($sformatf("unexpected result status=%0d count=%0d",
						status, entry_count));
				end else begin
					want = pending_outcomes.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
					if (entry_count !== want.entry_count)
						report_mismatch($sformatf("entry_count %0d, expected %0d",
							entry_count, want.entry_count));
				end
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("keyed_queue_remove_compact_unit test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty, duplicates, name endings, full, multi-match removal
		enqueue(OP_REMOVE, 64'h0, 8'h00, 8'h11);
		enqueue(OP_APPEND, 64'h0, 8'hFF, 8'h00);
		enqueue(OP_APPEND, '1, 8'hFF, 8'hFF);
		enqueue(OP_APPEND, 64'h4241, 8'h00, 8'h01);
		enqueue(OP_APPEND, 64'hDEADBEEFC0004241, 8'h77, 8'h02);
		enqueue(OP_APPEND, 64'h0102030405060708, 8'h5A, 8'h80);
		enqueue(OP_APPEND, 64'h0102030405060708, 8'hA5, 8'h7F);
		enqueue(OP_APPEND, 64'h4241, 8'h00, 8'h55);
		enqueue(OP_APPEND, 64'h00FFFFFFFFFFFFFF, 8'hFF, 8'hAA);
		enqueue(OP_APPEND, 64'h1, 8'h01, 8'h01);
		enqueue(OP_REMOVE, 64'h4241, 8'h00, 8'h00);
		enqueue(OP_REMOVE, 64'h4241, 8'h00, 8'hFF);
		enqueue(OP_REMOVE, 64'h1200, 8'h34, 8'h00);
		enqueue(OP_REMOVE, 64'h0102030405060708, 8'h5B, 8'h00);
		enqueue(OP_REMOVE, 64'h00FFFFFFFFFFFFFF, 8'h00, 8'h00);
		enqueue(OP_REMOVE, '1, 8'hFF, 8'h00);
		enqueue(OP_REMOVE, 64'h0102030405060708, 8'h5A, 8'h00);
		enqueue(OP_REMOVE, 64'h0102030405060708, 8'hA5, 8'h00);
		enqueue(OP_REMOVE, 64'h0102030405060708, 8'hA5, 8'h00);
		enqueue(OP_APPEND, 64'h0, 8'h00, 8'h10);
		enqueue(OP_APPEND, 64'hFF00, 8'hFF, 8'h20);
		enqueue(OP_REMOVE, 64'h0, 8'h00, 8'h00);
		wait_drained();

		queue_random_requests(185);
		wait_drained();

		sender_idle_pct = 87;
		queue_random_requests(185);
		wait_drained();

		sender_idle_pct = 0;
		receiver_stall_pct = 87;
		queue_random_requests(185);
		wait_drained();

		sender_idle_pct = 28;
		receiver_stall_pct = 28;
		queue_random_requests(185);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("keyed_queue_remove_compact_unit test passed");
		else
			$display("keyed_queue_remove_compact_unit test failed");
		$finish;
	end

endmodule
